@@ sv/sap_pkg.sv @@
// ----------------------------------------------------------------------------
// sap_pkg
// Shared widths, fixed-point constants and result codes of the shortest-arc
// quaternion pipeline.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int MAG_W     = 32;
  localparam int SQ_W      = 64;
  localparam int UNIT_FRAC = 30;
  localparam int UQ_W      = 31;
  localparam int CR_W      = 62;
  localparam int S_W       = 31;
  localparam int N_W       = 32;
  localparam int OUT_W     = 16;

  localparam logic signed [63:0] UNIT_Q30 = 64'sd1 <<< UNIT_FRAC;
  localparam logic signed [63:0] EPS_Q30  = 64'sd1074;

  typedef enum logic [1:0] {
    ARC_GENERAL = 2'd0,
    ARC_SAME    = 2'd1,
    ARC_HALF    = 2'd2
  } arc_case_t;

endpackage

@@ sv/shortest_arc_quaternion.sv @@
// ----------------------------------------------------------------------------
// shortest_arc_quaternion
// Fully pipelined shortest-arc rotation between two Q3.12 vectors. One
// vector pair can enter every cycle while the output is not stalled. The
// depth is set by the bit-serial stages: two 32-step square roots (vector
// length, quaternion norm), one 31-step root for the half-angle term, and
// the 31-, 32- and QUAT_FRAC_BITS+2-step dividers. A stalled output holds
// the whole pipeline in place; in_ready is low only while an unaccepted
// result is waiting.
// ----------------------------------------------------------------------------
module shortest_arc_quaternion #(
  parameter int COORD_WIDTH    = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     src_x,
  input  logic signed [COORD_WIDTH-1:0]     src_y,
  input  logic signed [COORD_WIDTH-1:0]     src_z,
  input  logic signed [COORD_WIDTH-1:0]     dst_x,
  input  logic signed [COORD_WIDTH-1:0]     dst_y,
  input  logic signed [COORD_WIDTH-1:0]     dst_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sap_pkg::OUT_W-1:0]  quat_w,
  output logic signed [sap_pkg::OUT_W-1:0]  quat_x,
  output logic signed [sap_pkg::OUT_W-1:0]  quat_y,
  output logic signed [sap_pkg::OUT_W-1:0]  quat_z,
  output logic [1:0]                        arc_case
);

  import sap_pkg::*;

  localparam int SARG_W = 2 * S_W;
  localparam int Q_W    = 32;
  localparam int ONUM_W = Q_W + QUAT_FRAC_BITS + 1;
  localparam int QO_W   = QUAT_FRAC_BITS + 2;
  localparam logic [63:0] ONE64 = 64'd1 << QUAT_FRAC_BITS;
  localparam logic [OUT_W-1:0] ONE_OUT = ONE64[OUT_W-1:0];

  logic en;

  logic                  src_vld, dst_vld, z0, z1;
  logic [2:0][MAG_W-1:0] u0, u1;

  logic                     t1_vld, t2_vld, t3_vld, t4_vld;
  logic signed [63:0]       t1_dot [3];
  logic signed [63:0]       t1_cp [3];
  logic signed [63:0]       t1_cn [3];
  logic                     t1_zero, t2_zero, t3_zero;
  logic signed [63:0]       t2_d60;
  logic signed [63:0]       t2_cr [3];
  logic signed [63:0]       t3_d30;
  logic [2:0][CR_W-1:0]     t3_cm, t4_cm;
  logic [2:0]               t3_cs, t4_cs;
  logic [1:0]               t4_case;
  logic [SARG_W-1:0]        t4_sarg;

  logic                     s_vld;
  logic [S_W-1:0]           s_root;
  logic [2+3+3*CR_W-1:0]    s_sb;
  logic [1:0]               s_case;
  logic [2:0]               s_cs;
  logic [2:0][CR_W-1:0]     s_cm;

  logic                     q_vld;
  logic [2:0][Q_W-1:0]      q_quo;
  logic [2+3+S_W-1:0]       q_sb;
  logic [1:0]               q_case;
  logic [2:0]               q_cs;
  logic [S_W-1:0]           q_s;

  logic                     t5_vld, t6_vld, t7_vld;
  logic [3:0][Q_W-1:0]      t5_qm, t6_qm;
  logic [SQ_W-1:0]          t5_sq [4];
  logic [SQ_W-1:0]          t6_sum;
  logic [1:0]               t5_case, t6_case, t7_case;
  logic [3:0]               t5_sgn, t6_sgn, t7_sgn;

  logic                     n_vld;
  logic [N_W-1:0]           n_root;
  logic [2+4+4*Q_W-1:0]     n_sb;
  logic [1:0]               n_case;
  logic [3:0]               n_sgn;
  logic [3:0][Q_W-1:0]      n_qm;

  logic [3:0][ONUM_W-1:0]   t7_num;
  logic [N_W-1:0]           t7_den;
  logic                     t7_nz;

  logic                     o_vld;
  logic [3:0][QO_W-1:0]     o_quo;
  logic [6:0]               o_sb;
  logic [1:0]               o_case;
  logic [3:0]               o_sgn;
  logic                     o_nz;

  logic [3:0][OUT_W-1:0]    res_c;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  sap_unit #(.COORD_WIDTH(COORD_WIDTH)) u_src (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .in_x     (src_x),
    .in_y     (src_y),
    .in_z     (src_z),
    .out_vld  (src_vld),
    .out_u    (u0),
    .out_zero (z0)
  );

  sap_unit #(.COORD_WIDTH(COORD_WIDTH)) u_dst (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .in_x     (dst_x),
    .in_y     (dst_y),
    .in_z     (dst_z),
    .out_vld  (dst_vld),
    .out_u    (u1),
    .out_zero (z1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld <= 1'b0;
      t2_vld <= 1'b0;
      t3_vld <= 1'b0;
      t4_vld <= 1'b0;
      t5_vld <= 1'b0;
      t6_vld <= 1'b0;
      t7_vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      t1_vld <= src_vld && dst_vld;
      t2_vld <= t1_vld;
      t3_vld <= t2_vld;
      t4_vld <= t3_vld;
      t5_vld <= q_vld;
      t6_vld <= t5_vld;
      t7_vld <= n_vld;
      out_valid <= o_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) t1_dot[i] <= $signed(u0[i]) * $signed(u1[i]);
      t1_cp[0] <= $signed(u0[1]) * $signed(u1[2]);
      t1_cn[0] <= $signed(u0[2]) * $signed(u1[1]);
      t1_cp[1] <= $signed(u0[2]) * $signed(u1[0]);
      t1_cn[1] <= $signed(u0[0]) * $signed(u1[2]);
      t1_cp[2] <= $signed(u0[0]) * $signed(u1[1]);
      t1_cn[2] <= $signed(u0[1]) * $signed(u1[0]);
      t1_zero  <= z0 || z1;

      t2_d60  <= t1_dot[0] + t1_dot[1] + t1_dot[2];
      for (int i = 0; i < 3; i++) t2_cr[i] <= t1_cp[i] - t1_cn[i];
      t2_zero <= t1_zero;

      t3_d30 <= t2_d60[63] ? ((t2_d60 + (UNIT_Q30 - 64'sd1)) >>> UNIT_FRAC)
                           : (t2_d60 >>> UNIT_FRAC);
      for (int i = 0; i < 3; i++) begin
        t3_cm[i] <= CR_W'(t2_cr[i][63] ? -t2_cr[i] : t2_cr[i]);
        t3_cs[i] <= t2_cr[i][63];
      end
      t3_zero <= t2_zero;

      if (t3_zero || t3_d30 >= UNIT_Q30) begin
        t4_case <= ARC_SAME;
      end else if (t3_d30 < EPS_Q30 - UNIT_Q30) begin
        t4_case <= ARC_HALF;
      end else begin
        t4_case <= ARC_GENERAL;
      end
      t4_sarg <= SARG_W'((t3_d30 + UNIT_Q30) <<< (UNIT_FRAC + 1));
      t4_cm   <= t3_cm;
      t4_cs   <= t3_cs;
    end
  end

  sap_isqrt #(
    .IN_W (SARG_W),
    .SB_W (2 + 3 + 3 * CR_W)
  ) u_half (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (t4_vld),
    .in_val   (t4_sarg),
    .in_sb    ({t4_case, t4_cs, t4_cm}),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_sb   (s_sb)
  );

  assign {s_case, s_cs, s_cm} = s_sb;

  sap_div #(
    .NUM_W (CR_W),
    .DEN_W (S_W),
    .QUO_W (Q_W),
    .LANES (3),
    .SB_W  (2 + 3 + S_W)
  ) u_vec_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_vld),
    .in_num  (s_cm),
    .in_den  (s_root),
    .in_sb   ({s_case, s_cs, s_root}),
    .out_vld (q_vld),
    .out_quo (q_quo),
    .out_sb  (q_sb)
  );

  assign {q_case, q_cs, q_s} = q_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      t5_qm   <= {q_quo, Q_W'(q_s >> 1)};
      t5_sq[0] <= Q_W'(q_s >> 1) * Q_W'(q_s >> 1);
      for (int i = 0; i < 3; i++) t5_sq[i+1] <= q_quo[i] * q_quo[i];
      t5_case <= q_case;
      t5_sgn  <= {q_cs, 1'b0};

      t6_sum  <= t5_sq[0] + t5_sq[1] + t5_sq[2] + t5_sq[3];
      t6_qm   <= t5_qm;
      t6_case <= t5_case;
      t6_sgn  <= t5_sgn;
    end
  end

  sap_isqrt #(
    .IN_W (SQ_W),
    .SB_W (2 + 4 + 4 * Q_W)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (t6_vld),
    .in_val   (t6_sum),
    .in_sb    ({t6_case, t6_sgn, t6_qm}),
    .out_vld  (n_vld),
    .out_root (n_root),
    .out_sb   (n_sb)
  );

  assign {n_case, n_sgn, n_qm} = n_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        t7_num[i] <= (ONUM_W'(n_qm[i]) << QUAT_FRAC_BITS) + ONUM_W'(n_root >> 1);
      end
      t7_den  <= n_root;
      t7_nz   <= n_root == '0;
      t7_case <= n_case;
      t7_sgn  <= n_sgn;
    end
  end

  sap_div #(
    .NUM_W (ONUM_W),
    .DEN_W (N_W),
    .QUO_W (QO_W),
    .LANES (4),
    .SB_W  (7)
  ) u_out_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (t7_vld),
    .in_num  (t7_num),
    .in_den  (t7_den),
    .in_sb   ({t7_case, t7_sgn, t7_nz}),
    .out_vld (o_vld),
    .out_quo (o_quo),
    .out_sb  (o_sb)
  );

  assign {o_case, o_sgn, o_nz} = o_sb;

  always_comb begin
    logic [63:0] r;
    logic [63:0] v;
    for (int i = 0; i < 4; i++) begin
      r = 64'(o_quo[i]);
      if (r > ONE64) r = ONE64;
      v = o_sgn[i] ? -r : r;
      res_c[i] = v[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (o_case == ARC_GENERAL && !o_nz) begin
        quat_w   <= res_c[0];
        quat_x   <= res_c[1];
        quat_y   <= res_c[2];
        quat_z   <= res_c[3];
        arc_case <= ARC_GENERAL;
      end else if (o_case == ARC_HALF) begin
        quat_w   <= '0;
        quat_x   <= '0;
        quat_y   <= ONE_OUT;
        quat_z   <= '0;
        arc_case <= ARC_HALF;
      end else begin
        quat_w   <= ONE_OUT;
        quat_x   <= '0;
        quat_y   <= '0;
        quat_z   <= '0;
        arc_case <= ARC_SAME;
      end
    end
  end

`ifndef SYNTH
  a_same_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && arc_case == ARC_SAME |-> quat_x == '0 && quat_y == '0 && quat_z == '0)
    else $error("identity result carries a nonzero vector part");

  a_half_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid && arc_case == ARC_HALF |-> quat_w == '0 && quat_x == '0 && quat_z == '0)
    else $error("half turn result not about the Y axis");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule

@@ sv/sap_isqrt.sv @@
// ----------------------------------------------------------------------------
// sap_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband that
// travels alongside.
// ----------------------------------------------------------------------------
module sap_isqrt #(
  parameter int IN_W = 64,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_val,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_vld,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int R = IN_W / 2;

  logic [IN_W-1:0] xs  [R];
  logic [R+1:0]    rem [R];
  logic [R-1:0]    rt  [R];
  logic            vld [R];
  logic [SB_W-1:0] sb  [R];

  for (genvar g = 0; g < R; g++) begin : g_stage
    logic [IN_W-1:0] x_c;
    logic [R+1:0]    rem_c;
    logic [R-1:0]    rt_c;
    logic            v_c;
    logic [SB_W-1:0] sb_c;
    logic [R+3:0]    rsh;
    logic [R+3:0]    trial;
    logic [R+3:0]    diff;
    logic            ge;

    if (g == 0) begin : g_first
      assign x_c   = in_val;
      assign rem_c = '0;
      assign rt_c  = '0;
      assign v_c   = in_vld;
      assign sb_c  = in_sb;
    end else begin : g_next
      assign x_c   = xs[g-1];
      assign rem_c = rem[g-1];
      assign rt_c  = rt[g-1];
      assign v_c   = vld[g-1];
      assign sb_c  = sb[g-1];
    end

    always_comb begin
      rsh   = {rem_c, x_c[IN_W-1 -: 2]};
      trial = {2'b00, rt_c, 2'b01};
      ge    = rsh >= trial;
      diff  = rsh - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[g]  <= x_c << 2;
        rem[g] <= ge ? diff[R+1:0] : rsh[R+1:0];
        rt[g]  <= {rt_c[R-2:0], ge};
        sb[g]  <= sb_c;
      end
    end
  end

  assign out_vld  = vld[R-1];
  assign out_root = rt[R-1];
  assign out_sb   = sb[R-1];

endmodule

@@ sv/sap_div.sv @@
// ----------------------------------------------------------------------------
// sap_div
// Pipelined restoring divider, one quotient bit per stage, several
// numerators over one shared divisor.
// ----------------------------------------------------------------------------
module sap_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 32,
  parameter int QUO_W = 31,
  parameter int LANES = 3,
  parameter int SB_W  = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]             in_den,
  input  logic [SB_W-1:0]              in_sb,
  output logic                         out_vld,
  output logic [LANES-1:0][QUO_W-1:0]  out_quo,
  output logic [SB_W-1:0]              out_sb
);

  logic [LANES-1:0][QUO_W-1:0] lo [QUO_W];
  logic [LANES-1:0][DEN_W-1:0] rr [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] qq [QUO_W];
  logic [DEN_W-1:0]            dd [QUO_W];
  logic                        vld [QUO_W];
  logic [SB_W-1:0]             sb [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [LANES-1:0][QUO_W-1:0] lo_c, q_c, lo_n, q_n;
    logic [LANES-1:0][DEN_W-1:0] r_c, r_n;
    logic [DEN_W-1:0]            d_c;
    logic                        v_c;
    logic [SB_W-1:0]             sb_c;

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          lo_c[l] = in_num[l][QUO_W-1:0];
          r_c[l]  = DEN_W'(in_num[l] >> QUO_W);
        end
      end
      assign q_c  = '0;
      assign d_c  = in_den;
      assign v_c  = in_vld;
      assign sb_c = in_sb;
    end else begin : g_next
      assign lo_c = lo[g-1];
      assign r_c  = rr[g-1];
      assign q_c  = qq[g-1];
      assign d_c  = dd[g-1];
      assign v_c  = vld[g-1];
      assign sb_c = sb[g-1];
    end

    always_comb begin
      logic [DEN_W:0] sh;
      for (int l = 0; l < LANES; l++) begin
        sh = {r_c[l], lo_c[l][QUO_W-1]};
        if (sh >= {1'b0, d_c}) begin
          r_n[l] = DEN_W'(sh - {1'b0, d_c});
          q_n[l] = {q_c[l][QUO_W-2:0], 1'b1};
        end else begin
          r_n[l] = sh[DEN_W-1:0];
          q_n[l] = {q_c[l][QUO_W-2:0], 1'b0};
        end
        lo_n[l] = lo_c[l] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo[g] <= lo_n;
        rr[g] <= r_n;
        qq[g] <= q_n;
        dd[g] <= d_c;
        sb[g] <= sb_c;
      end
    end
  end

  assign out_vld = vld[QUO_W-1];
  assign out_quo = qq[QUO_W-1];
  assign out_sb  = sb[QUO_W-1];

endmodule

@@ sv/sap_unit.sv @@
// ----------------------------------------------------------------------------
// sap_unit
// Vector normalizer: power-of-two prescale, length by square root, and
// division of each component by the length into Q1.30.
// ----------------------------------------------------------------------------
module sap_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic signed [COORD_WIDTH-1:0]         in_x,
  input  logic signed [COORD_WIDTH-1:0]         in_y,
  input  logic signed [COORD_WIDTH-1:0]         in_z,
  output logic                                  out_vld,
  output logic [2:0][sap_pkg::MAG_W-1:0]        out_u,
  output logic                                  out_zero
);

  import sap_pkg::*;

  localparam int SQ_SB_W = 3 * MAG_W + 4;

  logic [2:0][COORD_WIDTH-1:0] a;
  logic [2:0][MAG_W-1:0]       mag_c;
  logic [MAG_W-1:0]            max_c;

  logic                  s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;
  logic [2:0][MAG_W-1:0] s1_mag, s2_mag, s3_mag, s4_mag, s5_mag;
  logic [MAG_W-1:0]      s1_max, s2_max;
  logic [2:0]            s1_sgn, s2_sgn, s3_sgn, s4_sgn, s5_sgn;
  logic                  s1_zero, s2_zero, s3_zero, s4_zero, s5_zero;
  logic [SQ_W-1:0]       s4_sq [3];
  logic [SQ_W-1:0]       s5_sum;

  logic [MAG_W-1:0]      m2_c, m3_c;
  logic [2:0][MAG_W-1:0] v2_c, v3_c;

  logic                  len_vld;
  logic [N_W-1:0]        len;
  logic [SQ_SB_W-1:0]    len_sb;
  logic [2:0][MAG_W-1:0] len_mag;
  logic [2:0]            len_sgn;
  logic                  len_zero;

  logic [2:0][MAG_W+UNIT_FRAC-1:0] dv_num;
  logic                            dv_vld;
  logic [2:0][UQ_W-1:0]            dv_quo;
  logic [3:0]                      dv_sb;

  assign a = {in_z, in_y, in_x};

  always_comb begin
    logic [COORD_WIDTH-1:0] a_neg;
    for (int i = 0; i < 3; i++) begin
      a_neg    = ~a[i] + 1'b1;
      mag_c[i] = MAG_W'(a[i][COORD_WIDTH-1] ? a_neg : a[i]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  // prescale so that a nonzero largest magnitude lands in [2^30, 2^31)
  always_comb begin
    m2_c = s1_max;
    v2_c = s1_mag;
    if (m2_c[31:15] == '0) begin
      m2_c = m2_c << 16;
      for (int i = 0; i < 3; i++) v2_c[i] = v2_c[i] << 16;
    end
    if (m2_c[31:23] == '0) begin
      m2_c = m2_c << 8;
      for (int i = 0; i < 3; i++) v2_c[i] = v2_c[i] << 8;
    end
  end

  always_comb begin
    m3_c = s2_max;
    v3_c = s2_mag;
    if (m3_c[31:27] == '0) begin
      m3_c = m3_c << 4;
      for (int i = 0; i < 3; i++) v3_c[i] = v3_c[i] << 4;
    end
    if (m3_c[31:29] == '0) begin
      m3_c = m3_c << 2;
      for (int i = 0; i < 3; i++) v3_c[i] = v3_c[i] << 2;
    end
    if (m3_c[31:30] == '0) begin
      m3_c = m3_c << 1;
      for (int i = 0; i < 3; i++) v3_c[i] = v3_c[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      out_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag  <= mag_c;
      s1_max  <= max_c;
      s1_sgn  <= {a[2][COORD_WIDTH-1], a[1][COORD_WIDTH-1], a[0][COORD_WIDTH-1]};
      s1_zero <= max_c == '0;
      s2_mag  <= v2_c;
      s2_max  <= m2_c;
      s2_sgn  <= s1_sgn;
      s2_zero <= s1_zero;
      s3_mag  <= v3_c;
      s3_sgn  <= s2_sgn;
      s3_zero <= s2_zero;
      for (int i = 0; i < 3; i++) s4_sq[i] <= s3_mag[i] * s3_mag[i];
      s4_mag  <= s3_mag;
      s4_sgn  <= s3_sgn;
      s4_zero <= s3_zero;
      s5_sum  <= s4_sq[0] + s4_sq[1] + s4_sq[2];
      s5_mag  <= s4_mag;
      s5_sgn  <= s4_sgn;
      s5_zero <= s4_zero;
      for (int i = 0; i < 3; i++) begin
        out_u[i] <= dv_sb[i] ? -MAG_W'(dv_quo[i]) : MAG_W'(dv_quo[i]);
      end
      out_zero <= dv_sb[3];
    end
  end

  sap_isqrt #(
    .IN_W (SQ_W),
    .SB_W (SQ_SB_W)
  ) u_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s5_vld),
    .in_val   (s5_sum),
    .in_sb    ({s5_zero, s5_sgn, s5_mag}),
    .out_vld  (len_vld),
    .out_root (len),
    .out_sb   (len_sb)
  );

  assign {len_zero, len_sgn, len_mag} = len_sb;

  always_comb begin
    for (int i = 0; i < 3; i++) dv_num[i] = {len_mag[i], {UNIT_FRAC{1'b0}}};
  end

  sap_div #(
    .NUM_W (MAG_W + UNIT_FRAC),
    .DEN_W (N_W),
    .QUO_W (UQ_W),
    .LANES (3),
    .SB_W  (4)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (len_vld),
    .in_num  (dv_num),
    .in_den  (len),
    .in_sb   ({len_zero, len_sgn}),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_sb  (dv_sb)
  );

endmodule

@@ test/shortest_arc_quaternion_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_arc_quaternion_test
// Self-checking bench for the shortest-arc quaternion pipeline. Vector pairs
// are sent through the valid/ready input and each rotation leaving the block
// is compared field by field with a bit-exact integer rotation predictor.
// Directed corner cases come first, then random pairs under three idling
// mixes and a long output stall that fills the pipeline.
// ----------------------------------------------------------------------------
module shortest_arc_quaternion_test;
  import sap_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    arc_case_t   arc;
  } rotation_t;

  localparam int     FRAC      = 14;
  localparam longint ONE30     = 64'sd1 << 30;
  localparam int     LATENCY   = 174 + FRAC;
  localparam int     CYCLE_CAP = 2000000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] src_x, src_y, src_z;
  logic signed [15:0] dst_x, dst_y, dst_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0]         arc_case;

  rotation_t rotation_q[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  int        mismatches;
  int        pairs_sent;
  int        rotations_checked;
  int        case_seen[3];
  int        cycles;

  shortest_arc_quaternion dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_x     (src_x),
    .src_y     (src_y),
    .src_z     (src_z),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .dst_z     (dst_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .arc_case  (arc_case)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic u64_t root64(input u64_t v);
    u64_t r;
    u64_t b;
    r = 0;
    b = u64_t'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic u64_t mag(input longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic bit unit_vector(input longint a[3], output longint u[3]);
    u64_t   m;
    u64_t   sum;
    u64_t   len;
    longint scale;
    longint b[3];
    m = 0;
    sum = 0;
    scale = 1;
    u = '{0, 0, 0};
    for (int i = 0; i < 3; i++) if (mag(a[i]) > m) m = mag(a[i]);
    if (m == 0) return 1'b0;
    while (m * u64_t'(scale) < (u64_t'(1) << 30)) scale *= 2;
    for (int i = 0; i < 3; i++) begin
      b[i] = a[i] * scale;
      sum += u64_t'(b[i] * b[i]);
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) u[i] = (b[i] * ONE30) / longint'(len);
    return 1'b1;
  endfunction

  function automatic logic [15:0] scale_out(input longint q, input u64_t n);
    u64_t r;
    r = ((mag(q) << FRAC) + n / 2) / n;
    if (r > (u64_t'(1) << FRAC)) r = u64_t'(1) << FRAC;
    if (q < 0) r = -r;
    return r[15:0];
  endfunction

  function automatic rotation_t shortest_arc(input logic signed [15:0] sx, sy, sz,
                                             input logic signed [15:0] dx, dy, dz);
    longint    a[3];
    longint    b[3];
    longint    u0[3];
    longint    u1[3];
    longint    c[3];
    longint    q[4];
    longint    d30;
    longint    s;
    u64_t      sum;
    u64_t      n;
    bit        ok0;
    bit        ok1;
    rotation_t r;
    a = '{sx, sy, sz};
    b = '{dx, dy, dz};
    r.w = 16'(1 << FRAC);
    r.x = '0;
    r.y = '0;
    r.z = '0;
    r.arc = ARC_SAME;
    ok0 = unit_vector(a, u0);
    ok1 = unit_vector(b, u1);
    if (!ok0 || !ok1) return r;
    d30 = (u0[0] * u1[0] + u0[1] * u1[1] + u0[2] * u1[2]) / ONE30;
    if (d30 >= ONE30) return r;
    if (d30 < EPS_Q30 - ONE30) begin
      r.w = '0;
      r.y = 16'(1 << FRAC);
      r.arc = ARC_HALF;
      return r;
    end
    s = longint'(root64(u64_t'(2 * (ONE30 + d30)) << 30));
    if (s <= 0) s = 1;
    c[0] = u0[1] * u1[2] - u0[2] * u1[1];
    c[1] = u0[2] * u1[0] - u0[0] * u1[2];
    c[2] = u0[0] * u1[1] - u0[1] * u1[0];
    q[0] = s / 2;
    for (int i = 0; i < 3; i++) q[i + 1] = c[i] / s;
    sum = 0;
    for (int i = 0; i < 4; i++) sum += mag(q[i]) * mag(q[i]);
    n = root64(sum);
    if (n == 0) return r;
    r.w = scale_out(q[0], n);
    r.x = scale_out(q[1], n);
    r.y = scale_out(q[2], n);
    r.z = scale_out(q[3], n);
    r.arc = ARC_GENERAL;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d rotations pending", cycles,
               rotation_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rotation_t want;
    rotation_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{quat_w, quat_x, quat_y, quat_z, arc_case_t'(arc_case)};
      if (rotation_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rotation %h", got);
      end else begin
        want = rotation_q.pop_front();
        rotations_checked++;
        if (got.arc <= ARC_HALF) case_seen[got.arc]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch w %h/%h x %h/%h y %h/%h z %h/%h case %0d/%0d",
                     want.w, got.w, want.x, got.x, want.y, got.y,
                     want.z, got.z, want.arc, got.arc);
        end
      end
    end
  end

  task automatic send_pair(input logic signed [15:0] sx, sy, sz, dx, dy, dz);
    rotation_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    src_x <= sx;
    src_y <= sy;
    src_z <= sz;
    dst_x <= dx;
    dst_y <= dy;
    dst_z <= dz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected = shortest_arc(sx, sy, sz, dx, dy, dz);
    rotation_q = {rotation_q, expected};
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rotation_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] near(input logic signed [15:0] v);
    return v + 16'($signed($urandom_range(6)) - 3);
  endfunction

  task automatic send_random_pair();
    logic signed [15:0] s[3];
    logic signed [15:0] d[3];
    int                 kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      s[i] = (kind < 70) ? 16'($urandom) : 16'($signed($urandom_range(64)) - 32);
      d[i] = (kind < 50 || kind >= 70) ? 16'($urandom)
                                      : 16'($signed($urandom_range(64)) - 32);
    end
    if (kind >= 85) begin
      // steer toward the parallel and antiparallel branches
      for (int i = 0; i < 3; i++)
        d[i] = (kind >= 93) ? near(-s[i]) : near(s[i]);
    end
    if ($urandom_range(49) == 0) s = '{0, 0, 0};
    send_pair(s[0], s[1], s[2], d[0], d[1], d[2]);
  endtask

  task automatic test_corners();
    send_pair(0, 0, 0, 4096, 0, 0);
    send_pair(4096, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(4096, 0, 0, 4096, 0, 0);
    send_pair(4096, 0, 0, 8192, 0, 0);
    send_pair(4096, 0, 0, -4096, 0, 0);
    send_pair(0, 4096, 0, 0, -4096, 0);
    send_pair(4096, 0, 0, 0, 4096, 0);
    send_pair(0, 4096, 0, 0, 0, 4096);
    send_pair(0, 0, 4096, 4096, 0, 0);
    send_pair(32767, 32767, 32767, -32768, -32768, -32768);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(32767, -32768, 32767, -32768, 32767, -32768);
    send_pair(-32768, 0, 0, 32767, 0, 0);
    send_pair(1, 0, 0, 0, 0, -1);
    send_pair(1, 1, 1, -1, -1, -1);
    send_pair(1, 0, 0, -1, 1, 0);
    send_pair(32767, 1, 0, -32768, 0, 0);
    send_pair(32767, 0, 0, -32767, 2, 0);
    send_pair(32767, 0, 0, 32767, 1, 0);
    send_pair(100, -200, 300, -300, 200, -100);
    send_pair(-1, -1, -1, 32767, -32768, 1);
    drain();
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_pair();
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    hold_cycles = 3 * LATENCY;
    repeat (300) send_random_pair();
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {src_x, src_y, src_z, dst_x, dst_y, dst_z} = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    pairs_sent = 0;
    rotations_checked = 0;
    case_seen = '{0, 0, 0};
    cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_corners();
    test_random(500, 35, 49);
    test_random(500, 49, 35);
    test_random(500, 0, 0);
    test_backpressure();

    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d vector pairs, %0d rotations checked (general %0d, same %0d, half %0d)",
             pairs_sent, rotations_checked, case_seen[0], case_seen[1], case_seen[2]);
    $display("covered corners, three idling mixes and a full-pipeline output stall");
    if (mismatches == 0 && rotation_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d rotations missing", mismatches, rotation_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sap_pkg.sv
sv/sap_isqrt.sv
sv/sap_div.sv
sv/sap_unit.sv
sv/shortest_arc_quaternion.sv
test/shortest_arc_quaternion_test.sv
